FILE: src/assert_macros.svh
// Assertion helpers for RTL files that check their own logic.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/hdu_pkg.sv
// ----------------------------------------------------------------------------
// hdu_pkg: shared definitions for the horizontal 2:1 downsampler
// Field widths, filter constants, register indexes and the stage record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdu_pkg;

  // Field widths
  localparam int PIX_W          = 8;
  localparam int WIDTH_W        = 13;
  localparam int MAX_LINE_WIDTH = 4096;
  localparam int MIN_LINE_WIDTH = 2;
  localparam int POS_W          = $clog2(MAX_LINE_WIDTH);
  localparam int CMP_W          = WIDTH_W + 1;

  // Filter arithmetic
  localparam int SUM_W        = 14;
  localparam int COSITE_RND   = 2;
  localparam int COSITE_SHIFT = 2;
  localparam int HALF_OUTER   = 6;
  localparam int HALF_INNER   = 26;
  localparam int HALF_RND     = 32;
  localparam int HALF_SHIFT   = 6;
  localparam int PIX_MAX      = 255;

  // Register reset values
  localparam logic               MODE_RESET  = 1'b1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1920;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE  = 1'b0,
    CFG_SOURCE_WIDTH = 1'b1
  } cfg_idx_e;

  // One item between the window stage and the filter stage
  typedef struct packed {
    logic [3:0][PIX_W-1:0] taps;      // taps[0] is the oldest pixel
    logic                  cosite;
    logic                  line_end;
  } stage_t;

endpackage

`default_nettype wire

FILE: src/horizontal_two_to_one_downsample_unit.sv
// ----------------------------------------------------------------------------
// horizontal_two_to_one_downsample_unit: 2:1 horizontal line decimator
// Filters and halves each line of 8-bit pixels with edge replication.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels of a line enter on the slave stream, left to right, one per
//   transaction (tdata[7:0] = pixel). Each line gives floor(W/2) results on
//   the master stream (tdata[7:0] = pixel, tlast on the last one of a line).
//   The config port writes register 0 (filter mode, 1 = cosite 1-2-1,
//   0 = halfsite 6-26-26-6) and register 1 (source line width, clamped to
//   2..4096); write it only while the block is idle.
//   Throughput is one source pixel per cycle while the receiver keeps up; a
//   result reaches the master side through the window stage register
//   followed by the output register.
//   When the receiver stalls, the output register holds its result and the
//   window stage holds one more; the slave side then drops tready until the
//   stage drains.
//   Reset clears the pixel window and line position, sets cosite mode and a
//   width of 1920, and empties both pipeline registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module horizontal_two_to_one_downsample_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hdu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hdu_pkg::WIDTH_W-1:0]    cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] in_pixel
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [7:0]                     m_axis_tdata,   // [7:0] out_pixel
  output      logic                           m_axis_tlast
);

  logic            st_valid;
  logic            st_ready;
  hdu_pkg::stage_t st;

  // Window, position and tap selection
  hdu_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_pixel_i  (s_axis_tdata),
    .st_valid_o  (st_valid),
    .st_o        (st),
    .st_ready_i  (st_ready)
  );

  // Filter arithmetic and output register
  hdu_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_valid_i  (st_valid),
    .st_i        (st),
    .st_ready_o  (st_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // Input back-pressure only comes from a full window stage
  `ASSERT_IMPL(a_ready_low_stage_full, !s_axis_tready, st_valid)
  // A stalled stage keeps its item
  `ASSERT_NEXT(a_stage_holds, st_valid && !st_ready, st_valid && $stable(st))
  // A taken result with nothing behind it leaves the output empty
  `ASSERT_NEXT(a_no_repeat, m_axis_tvalid && m_axis_tready && !st_valid, !m_axis_tvalid)

endmodule

`default_nettype wire

FILE: src/hdu_window.sv
// ----------------------------------------------------------------------------
// hdu_window: configuration, pixel window and line position tracking
// Picks the taps and the end-of-line flag for every emitting source pixel
// and holds them in the stage register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdu_window (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hdu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hdu_pkg::WIDTH_W-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [hdu_pkg::PIX_W-1:0]      in_pixel_i,
  output      logic                           st_valid_o,
  output      hdu_pkg::stage_t                st_o,
  input  wire logic                           st_ready_i
);

  logic                         mode_q;
  logic [hdu_pkg::WIDTH_W-1:0]  width_q;
  logic [hdu_pkg::PIX_W-1:0]    win_q [3];
  logic [hdu_pkg::POS_W-1:0]    pos_q;
  logic                         st_valid_q;
  hdu_pkg::stage_t              st_q;
  hdu_pkg::stage_t              st_d;

  logic [hdu_pkg::WIDTH_W-1:0]  eff_w;
  logic [hdu_pkg::PIX_W-1:0]    w0, w1, w2;
  logic                         pos_zero, odd, last, flag_co, emit, accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= hdu_pkg::MODE_RESET;
      width_q <= hdu_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdu_pkg::CFG_FILTER_MODE:  mode_q  <= cfg_wdata_i[0];
        hdu_pkg::CFG_SOURCE_WIDTH: width_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the line width to the supported range
  always_comb begin
    if (width_q < hdu_pkg::WIDTH_W'(hdu_pkg::MIN_LINE_WIDTH)) begin
      eff_w = hdu_pkg::WIDTH_W'(hdu_pkg::MIN_LINE_WIDTH);
    end else if (width_q > hdu_pkg::WIDTH_W'(hdu_pkg::MAX_LINE_WIDTH)) begin
      eff_w = hdu_pkg::WIDTH_W'(hdu_pkg::MAX_LINE_WIDTH);
    end else begin
      eff_w = width_q;
    end
  end

  // Position decode
  assign pos_zero = (pos_q == '0);
  assign odd      = pos_q[0];
  assign last     = (hdu_pkg::CMP_W'(pos_q) + hdu_pkg::CMP_W'(1)) >= hdu_pkg::CMP_W'(eff_w);
  assign flag_co  = (hdu_pkg::CMP_W'(pos_q) + hdu_pkg::CMP_W'(2)) >= hdu_pkg::CMP_W'(eff_w);

  // Replicate the first pixel of a line into the whole window
  assign w0 = pos_zero ? in_pixel_i : win_q[0];
  assign w1 = pos_zero ? in_pixel_i : win_q[1];
  assign w2 = pos_zero ? in_pixel_i : win_q[2];

  // Cosite emits on odd positions; halfsite on even ones past the first,
  // and on the last pixel of an even-width line
  assign emit = mode_q ? odd : ((!odd && !pos_zero) || (odd && last));

  // Select taps and the end-of-line flag
  always_comb begin
    st_d.cosite = mode_q;
    if (!mode_q && !odd) begin
      st_d.taps     = {in_pixel_i, w0, w1, w2};
      st_d.line_end = last;
    end else begin
      st_d.taps     = {in_pixel_i, in_pixel_i, w0, w1};
      st_d.line_end = mode_q ? flag_co : 1'b1;
    end
  end

  assign in_ready_o = !st_valid_q || st_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Shift the window and advance the position on every transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
      pos_q    <= '0;
    end else if (accept) begin
      win_q[2] <= w1;
      win_q[1] <= w0;
      win_q[0] <= in_pixel_i;
      pos_q    <= last ? '0 : pos_q + hdu_pkg::POS_W'(1);
    end
  end

  // Stage register: load on emitting transactions, drain when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (accept && emit) begin
      st_valid_q <= 1'b1;
    end else if (st_ready_i) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      st_q <= st_d;
    end
  end

  assign st_valid_o = st_valid_q;
  assign st_o       = st_q;

endmodule

`default_nettype wire

FILE: src/hdu_filter.sv
// ----------------------------------------------------------------------------
// hdu_filter: FIR arithmetic and output register
// Weights three taps (cosite) or four (halfsite), rounds, shifts and clamps
// to a byte, then holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdu_filter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       st_valid_i,
  input  wire hdu_pkg::stage_t            st_i,
  output      logic                       st_ready_o,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [hdu_pkg::PIX_W-1:0]  out_pixel_o,
  output      logic                       out_last_o
);

  logic [hdu_pkg::SUM_W-1:0]  t0, t1, t2, t3;
  logic [hdu_pkg::SUM_W-1:0]  sum_co, sum_hs, scaled;
  logic [hdu_pkg::PIX_W-1:0]  pixel_d, pixel_q;
  logic                       out_valid_q, last_q, load;

  assign t0 = hdu_pkg::SUM_W'(st_i.taps[0]);
  assign t1 = hdu_pkg::SUM_W'(st_i.taps[1]);
  assign t2 = hdu_pkg::SUM_W'(st_i.taps[2]);
  assign t3 = hdu_pkg::SUM_W'(st_i.taps[3]);

  // 1-2-1 and 6-26-26-6 kernels with rounding
  assign sum_co = t0 + (t1 << 1) + t2 + hdu_pkg::SUM_W'(hdu_pkg::COSITE_RND);
  assign sum_hs = t0 * hdu_pkg::SUM_W'(hdu_pkg::HALF_OUTER)
                + t1 * hdu_pkg::SUM_W'(hdu_pkg::HALF_INNER)
                + t2 * hdu_pkg::SUM_W'(hdu_pkg::HALF_INNER)
                + t3 * hdu_pkg::SUM_W'(hdu_pkg::HALF_OUTER)
                + hdu_pkg::SUM_W'(hdu_pkg::HALF_RND);

  assign scaled = st_i.cosite ? (sum_co >> hdu_pkg::COSITE_SHIFT)
                              : (sum_hs >> hdu_pkg::HALF_SHIFT);

  // Clamp to the byte range
  always_comb begin
    if (scaled > hdu_pkg::SUM_W'(hdu_pkg::PIX_MAX)) begin
      pixel_d = hdu_pkg::PIX_W'(hdu_pkg::PIX_MAX);
    end else begin
      pixel_d = scaled[hdu_pkg::PIX_W-1:0];
    end
  end

  assign st_ready_o = !out_valid_q || out_ready_i;
  assign load       = st_valid_i && st_ready_o;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_q <= pixel_d;
      last_q  <= st_i.line_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = pixel_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the horizontal 2:1 line decimator
// Streams 8-bit source pixels through the unit in cosite and halfsite mode
// over many line widths, and compares each decimated pixel and its line-end
// flag with a cycle-free predictor. A short table of directed lines and
// width changes comes first, then random lines. Both stream sides idle at
// random. One long receiver hold-off backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import hdu_pkg::*;

  localparam int ITEM_TARGET    = 800;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLDOFF_CYCLES = 100;
  localparam int IDLE_PCT       = 19;
  localparam int DIRECTED_ROWS  = 31;

  typedef enum logic {
    ROW_WRITE,
    ROW_PIXEL
  } row_kind_e;

  // One directed step: a register write or a pixel, with an optional
  // hand-computed result for that pixel
  typedef struct packed {
    row_kind_e          kind;
    cfg_idx_e           idx;
    logic [WIDTH_W-1:0] value;
    logic [PIX_W-1:0]   pix;
    logic               typed;
    logic [PIX_W-1:0]   want_pix;
    logic               want_last;
  } row_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             line_end;
  } decimated_t;

  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // cosite, width 1920 after reset; left edge replicates 255
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b1, 8'd191, 1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
    // shrink the width mid-line: next pixel ends the line with no result
    '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd4,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd128, 1'b0, 8'd0,   1'b0},
    // cosite line of four zeros
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b1, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b1, 8'd0,   1'b1},
    // halfsite line of four full-scale pixels
    '{ROW_WRITE, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b1, 8'd255, 1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b1, 8'd255, 1'b1},
    // width zero acts as two; halfsite end of an even line
    '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b1, 8'd128, 1'b1},
    // cosite, two-pixel line
    '{ROW_WRITE, CFG_FILTER_MODE,  13'd1,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b1, 8'd191, 1'b1},
    // width one acts as two
    '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd1,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b1, 8'd0,   1'b1},
    // width above the maximum, then cut to three mid-line in halfsite
    '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd8191, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WRITE, CFG_FILTER_MODE,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd10,  1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd20,  1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd30,  1'b0, 8'd0,   1'b0},
    '{ROW_WRITE, CFG_SOURCE_WIDTH, 13'd3,    8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_PIXEL, CFG_FILTER_MODE,  13'd0,    8'd40,  1'b0, 8'd0,   1'b0}
  };

  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  cfg_idx_e           cfg_idx   = CFG_FILTER_MODE;
  logic [WIDTH_W-1:0] cfg_wdata = '0;
  logic               s_tvalid  = 1'b0;
  logic [7:0]         s_tdata   = '0;
  logic               s_tready;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [7:0]         m_tdata;
  logic               m_tlast;

  // Predictor state: registers, pixel window (newest first), line position
  logic               cur_mode  = 1'b1;
  logic [WIDTH_W-1:0] cur_width = 13'd1920;
  logic [PIX_W-1:0]   win [3]   = '{8'd0, 8'd0, 8'd0};
  int                 line_pos  = 0;

  decimated_t decimated_q [$];
  int         fail_count      = 0;
  int         cycle_count     = 0;
  bit         steady          = 1'b0;
  bit         holdoff_request = 1'b0;
  int         holdoff_left    = 0;

  horizontal_two_to_one_downsample_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Line width as the unit applies it
  function automatic int eff_width();
    int w;
    w = int'(cur_width);
    if (w < MIN_LINE_WIDTH) w = MIN_LINE_WIDTH;
    if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
    return w;
  endfunction

  // Advance the predictor by one source pixel; return 1 when it completes
  // a decimated pixel
  function automatic bit decimate_step(input logic [PIX_W-1:0] px,
                                       output decimated_t res);
    int w;
    int sum;
    int value;
    bit ends;
    bit emit;
    w     = eff_width();
    ends  = (line_pos + 1 >= w);
    emit  = 1'b0;
    value = 0;
    res   = '0;
    // Replicate the left edge
    if (line_pos == 0) win = '{px, px, px};
    if (cur_mode) begin
      if (line_pos % 2 == 1) begin
        sum          = win[1] + 2 * win[0] + px;
        value        = (sum + 2) >> 2;
        res.line_end = (line_pos + 2 >= w);
        emit         = 1'b1;
      end
    end else if (line_pos % 2 == 0 && line_pos >= 2) begin
      sum          = 6 * win[2] + 26 * win[1] + 26 * win[0] + 6 * px;
      value        = (sum + 32) >> 6;
      res.line_end = ends;
      emit         = 1'b1;
    end else if (line_pos % 2 == 1 && ends) begin
      // Right tap clamps onto the last pixel of an even line
      sum          = 6 * win[1] + 26 * win[0] + 32 * px;
      value        = (sum + 32) >> 6;
      res.line_end = 1'b1;
      emit         = 1'b1;
    end
    if (value > 255) value = 255;
    res.pix  = value[PIX_W-1:0];
    win[2]   = win[1];
    win[1]   = win[0];
    win[0]   = px;
    line_pos = ends ? 0 : line_pos + 1;
    return emit;
  endfunction

  // Offer one pixel after an optional random gap; valid stays high on return
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input decimated_t typed_res);
    decimated_t res;
    int         gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk_i); while (!s_tready);
    if (decimate_step(px, res)) decimated_q.push_back(typed ? typed_res : res);
  endtask

  // Drop valid and wait until every pending result has been checked
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decimated_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let the pipeline empty of pixels that make no result
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WIDTH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_FILTER_MODE) cur_mode = value[0];
    else cur_width = value;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else if (holdoff_request) begin
      holdoff_request = 1'b0;
      holdoff_left    = HOLDOFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each output transaction with the oldest expected pixel
  always @(posedge clk_i) begin : check_output
    decimated_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (decimated_q.size() == 0) begin
        $error("unexpected output: out_pixel %0d, line_end %0b", m_tdata, m_tlast);
        fail_count++;
      end else begin
        want = decimated_q.pop_front();
        if (m_tdata !== want.pix) begin
          $error("out_pixel: expected %0d, actual %0d", want.pix, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.line_end) begin
          $error("line_end: expected %0b, actual %0b", want.line_end, m_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t               row;
    decimated_t         typed_res;
    logic [WIDTH_W-1:0] width_val;
    logic [PIX_W-1:0]   px;
    int                 random_sent;
    int                 phase;
    int                 pick;
    int                 w;
    int                 n;
    bit                 long_line;
    random_sent = 0;
    phase       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.idx, row.value);
      end else begin
        typed_res.pix      = row.want_pix;
        typed_res.line_end = row.want_last;
        send_pixel(row.pix, row.typed, typed_res);
      end
    end

    // Random phases: new mode and width, then mostly whole lines
    typed_res = '0;
    while (random_sent < ITEM_TARGET) begin
      steady = (phase >= 8 && phase < 13);
      settle();
      write_reg(CFG_FILTER_MODE, WIDTH_W'($urandom_range(1)));
      pick      = $urandom_range(99);
      long_line = 1'b0;
      if (phase == 4) begin
        width_val = 13'd8191;
        long_line = 1'b1;
      end
      else if (pick < 70) width_val = WIDTH_W'($urandom_range(24, 2));
      else if (pick < 85) width_val = WIDTH_W'($urandom_range(300, 25));
      else if (pick < 92) width_val = WIDTH_W'($urandom_range(1));
      else begin
        width_val = WIDTH_W'($urandom_range(8191, 2));
        long_line = 1'b1;
      end
      write_reg(CFG_SOURCE_WIDTH, width_val);
      w = eff_width();
      if (long_line) begin
        // Leave the line open; the next width write cuts it
        n = $urandom_range(40, 1);
      end else begin
        n = (line_pos >= w - 1) ? 1 : w - line_pos;
        n += $urandom_range(w > 64 ? 1 : 3) * w;
        if ($urandom_range(3) == 0) n += $urandom_range(w - 1 < 40 ? w - 1 : 40, 1);
      end
      if (phase == 1) begin
        n += 40;
        holdoff_request = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        if (phase == 2 && i == n / 2) drain();
        if ($urandom_range(9) == 0) px = $urandom_range(1) ? 8'hFF : 8'h00;
        else px = PIX_W'($urandom_range(255));
        send_pixel(px, 1'b0, typed_res);
        random_sent++;
      end
      phase++;
    end

    steady = 1'b0;
    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
